@@ rtl/riffx_pkg.sv @@
// Package for the RIFF/WebP EXIF extractor: container tags, header sizes and
// the transaction and result types shared by the pipeline stages.
// No dependencies.
`default_nettype none

package riffx_pkg;

   // Four-character tags, first character in the top byte
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WEBP = 32'h5745_4250;
   localparam logic [31:0] TAG_EXIF = 32'h4558_4946;

   // Container layout
   localparam int TAG_BYTES       = 4;
   localparam int CHUNK_HDR_BYTES = 8;
   localparam int WALK_START      = 12;

   // Result kinds
   localparam logic KIND_EXIF = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       stream_start;
   } item_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] payload_byte;
      logic       payload_last;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/riffx_in_stage.sv @@
// Input register of the EXIF extractor: captures one request transaction and
// holds it until the parser can consume it. Depends on riffx_pkg.
`default_nettype none

module riffx_in_stage
   import riffx_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic [7:0]             req_byte_value,
   input  wire logic [31:0]            req_total_length,
   input  wire logic                   req_stream_start,
   output logic                        req_stall,
   input  wire logic                   advance,
   output logic                        item_valid,
   output item_type                    item,
   output logic [LENGTH_BITS-1:0]      item_total
);

   logic                   valid_ff;
   item_type               item_ff;
   logic [LENGTH_BITS-1:0] total_ff;

   // Hold while an item sits here and the result side cannot take its result
   assign req_stall  = valid_ff && !advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;
   assign item_total = total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.byte_value   <= req_byte_value;
         item_ff.stream_start <= req_stream_start;
         total_ff             <= req_total_length[LENGTH_BITS-1:0];
      end
   end

endmodule

`default_nettype wire

@@ rtl/riffx_parser.sv @@
// Chunk walker of the EXIF extractor: parse state registers and the one-byte
// step logic that decides each byte's result. Depends on riffx_pkg.
`default_nettype none

module riffx_parser
   import riffx_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire item_type               item,
   input  wire logic [LENGTH_BITS-1:0] total,
   output logic                        res_valid,
   output rsp_type                     res
);

   localparam logic [2:0] MODE_FILE_HDR  = 3'd0;
   localparam logic [2:0] MODE_CHUNK_HDR = 3'd1;
   localparam logic [2:0] MODE_SKIP      = 3'd2;
   localparam logic [2:0] MODE_PAD       = 3'd3;
   localparam logic [2:0] MODE_EXIF      = 3'd4;
   localparam logic [2:0] MODE_STOP      = 3'd5;
   localparam logic [2:0] MODE_FOUND     = 3'd6;

   localparam int SUM_BITS = 34;

   logic [LENGTH_BITS-1:0] pos_ff,  pos_in;
   logic [2:0]             mode_ff, mode_in;
   logic [31:0]            tag_ff,  tag_in;
   logic [31:0]            len_ff,  len_in;
   logic [LENGTH_BITS-1:0] cnt_ff,  cnt_in;
   logic                   pad_ff,  pad_in;

   always_comb begin
      logic [LENGTH_BITS-1:0] pos_e;
      logic [2:0]             mode_e;
      logic [31:0]            tag_e;
      logic [31:0]            len_e;
      logic [LENGTH_BITS-1:0] cnt_e;
      logic                   pad_e;
      logic                   active;
      logic [31:0]            tag_sh;
      logic [31:0]            len_sh;
      logic [LENGTH_BITS-1:0] cnt_dec;
      logic                   overrun;
      logic                   last_byte;
      logic                   emit;
      logic                   emit_last;

      // A stream start clears all parse state before the byte is taken
      pos_e  = item.stream_start ? '0 : pos_ff;
      mode_e = item.stream_start ? MODE_FILE_HDR : mode_ff;
      tag_e  = item.stream_start ? '0 : tag_ff;
      len_e  = item.stream_start ? '0 : len_ff;
      cnt_e  = item.stream_start ? '0 : cnt_ff;
      pad_e  = item.stream_start ? 1'b0 : pad_ff;

      active  = step && (pos_e < total);
      tag_sh  = {tag_e[23:0], item.byte_value};
      len_sh  = {item.byte_value, len_e[31:8]};
      cnt_dec = (cnt_e != '0) ? cnt_e - LENGTH_BITS'(1) : cnt_e;
      overrun = (SUM_BITS'(pos_e) + SUM_BITS'(1) + SUM_BITS'(len_sh)) > SUM_BITS'(total);
      last_byte = (pos_e == total - LENGTH_BITS'(1));

      mode_in   = mode_e;
      tag_in    = tag_e;
      len_in    = len_e;
      cnt_in    = cnt_e;
      pad_in    = pad_e;
      emit      = 1'b0;
      emit_last = 1'b0;

      if (active) begin
         unique case (mode_e)
            MODE_FILE_HDR: begin
               tag_in = tag_sh;
               if (pos_e == LENGTH_BITS'(TAG_BYTES - 1) && tag_sh != TAG_RIFF) begin
                  mode_in = MODE_STOP;
               end else if (pos_e == LENGTH_BITS'(WALK_START - 1)) begin
                  if (tag_sh != TAG_WEBP) begin
                     mode_in = MODE_STOP;
                  end else begin
                     mode_in = MODE_CHUNK_HDR;
                     cnt_in  = '0;
                     pad_in  = 1'b0;
                  end
               end
            end
            MODE_CHUNK_HDR: begin
               if (cnt_e < LENGTH_BITS'(TAG_BYTES)) begin
                  tag_in = tag_sh;
               end else begin
                  len_in = len_sh;
               end
               cnt_in = cnt_e + LENGTH_BITS'(1);
               // Last header byte: decide from the completed length
               if (cnt_e == LENGTH_BITS'(CHUNK_HDR_BYTES - 1)) begin
                  if (overrun) begin
                     mode_in = MODE_STOP;
                  end else if (len_sh == '0) begin
                     mode_in = MODE_CHUNK_HDR;
                     cnt_in  = '0;
                     pad_in  = 1'b0;
                  end else if (tag_e == TAG_EXIF) begin
                     mode_in = MODE_EXIF;
                     cnt_in  = len_sh[LENGTH_BITS-1:0];
                  end else begin
                     mode_in = MODE_SKIP;
                     cnt_in  = len_sh[LENGTH_BITS-1:0];
                     pad_in  = len_sh[0];
                  end
               end
            end
            MODE_SKIP: begin
               cnt_in = cnt_dec;
               if (cnt_dec == '0) begin
                  if (pad_e) begin
                     mode_in = MODE_PAD;
                  end else begin
                     mode_in = MODE_CHUNK_HDR;
                     pad_in  = 1'b0;
                  end
               end
            end
            MODE_PAD: begin
               mode_in = MODE_CHUNK_HDR;
               cnt_in  = '0;
               pad_in  = 1'b0;
            end
            MODE_EXIF: begin
               emit   = 1'b1;
               cnt_in = cnt_dec;
               if (cnt_dec == '0) begin
                  emit_last = 1'b1;
                  mode_in   = MODE_FOUND;
               end
            end
            default: begin
               // walk stopped or EXIF done: only the position advances
            end
         endcase
      end

      pos_in = active ? pos_e + LENGTH_BITS'(1) : pos_e;

      res_valid        = active && (emit || (mode_in != MODE_FOUND && last_byte));
      res.result_kind  = emit ? KIND_EXIF : KIND_END;
      res.payload_byte = emit ? item.byte_value : 8'h00;
      res.payload_last = emit ? emit_last : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         mode_ff <= MODE_FILE_HDR;
         tag_ff  <= '0;
         len_ff  <= '0;
         cnt_ff  <= '0;
         pad_ff  <= 1'b0;
      end else if (step) begin
         pos_ff  <= pos_in;
         mode_ff <= mode_in;
         tag_ff  <= tag_in;
         len_ff  <= len_in;
         cnt_ff  <= cnt_in;
         pad_ff  <= pad_in;
      end
   end

`ifndef SYNTHESIS
   // An EXIF payload in progress always has bytes left to send
   a_exif_count_live: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_EXIF) |-> (cnt_ff != '0))
      else $error("EXIF mode with zero bytes left");

   // Once the EXIF payload is done, only a new stream leaves that mode
   a_found_sticky: assert property (@(posedge clock) disable iff (reset)
      (step && !item.stream_start && mode_ff == MODE_FOUND) |=> (mode_ff == MODE_FOUND))
      else $error("left EXIF-done mode without stream start");
`endif

endmodule

`default_nettype wire

@@ rtl/riffx_out_stage.sv @@
// Result register of the EXIF extractor: holds one response transaction until
// the receiver takes it. Depends on riffx_pkg.
`default_nettype none

module riffx_out_stage
   import riffx_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire logic    res_valid,
   input  wire rsp_type res,
   output logic         free,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic         rsp_result_kind,
   output logic [7:0]   rsp_payload_byte,
   output logic         rsp_payload_last
);

   logic    valid_ff;
   rsp_type res_ff;

   // Slot is free when empty or being drained this cycle
   assign free             = !valid_ff || !rsp_stall;
   assign rsp_valid        = valid_ff;
   assign rsp_result_kind  = res_ff.result_kind;
   assign rsp_payload_byte = res_ff.payload_byte;
   assign rsp_payload_last = res_ff.payload_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= load && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (free && load && res_valid) begin
         res_ff <= res;
      end
   end

`ifndef SYNTHESIS
   // Reset empties the result slot
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !valid_ff)
      else $error("result register valid after reset");
`endif

endmodule

`default_nettype wire

@@ rtl/riff_exif_chunk_extractor.sv @@
// Top level of the RIFF/WebP EXIF extractor: input register, chunk walker and
// result register. Depends on riffx_pkg, riffx_in_stage, riffx_parser,
// riffx_out_stage.
//
// Usage:
//   Request channel (req_*): one file byte per transaction with the file's
//   total length; req_stream_start marks byte 0 of a new file and restarts
//   parsing. Response channel (rsp_*): zero or one transaction per byte:
//   either an EXIF payload byte (kind 0, last marked on its final byte) or,
//   on the file's last byte when no EXIF payload was delivered, one end
//   marker (kind 1, byte 0, last 1). Bytes at or past the total length are
//   absorbed without effect.
//   Path: an accepted request is held in the input register, parsed and then
//   loaded into the result register, from which its response is presented.
//   Throughput: one byte per cycle while the result slot is free, set by the
//   combinational parse step between the two registers.
//   Stalls: while rsp_stall holds a waiting response, the parser freezes and
//   the input register keeps one byte, after which req_stall rises. A free
//   result slot lets a new byte enter every cycle.
//   Reset (synchronous, active high): both registers empty, parse state
//   returns to the file header check at position zero.
`default_nettype none

module riff_exif_chunk_extractor
   import riffx_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic [31:0] req_total_length,
   input  wire logic        req_stream_start,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_result_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_payload_last
);

   logic                   out_free;
   logic                   item_valid;
   item_type               item;
   logic [LENGTH_BITS-1:0] item_total;
   logic                   step;
   logic                   res_valid;
   rsp_type                res;

   // Advance the held byte through the parser only when its result has room
   assign step = item_valid && out_free;

   riffx_in_stage #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_in_stage (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_byte_value   (req_byte_value),
      .req_total_length (req_total_length),
      .req_stream_start (req_stream_start),
      .req_stall        (req_stall),
      .advance          (out_free),
      .item_valid       (item_valid),
      .item             (item),
      .item_total       (item_total)
   );

   riffx_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (item),
      .total     (item_total),
      .res_valid (res_valid),
      .res       (res)
   );

   riffx_out_stage u_out_stage (
      .clock            (clock),
      .reset            (reset),
      .load             (step),
      .res_valid        (res_valid),
      .res              (res),
      .free             (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_last (rsp_payload_last)
   );

`ifndef SYNTHESIS
   // Input backpressure only comes from a held byte behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (item_valid && rsp_valid && rsp_stall))
      else $error("request stalled without a blocked response");
`endif

endmodule

`default_nettype wire

@@ sim/tb_riff_exif_chunk_extractor.sv @@
// Testbench for riff_exif_chunk_extractor: a directed table and random WebP-like files,
// with a built-in chunk walker that predicts every EXIF byte and end marker.
// Depends on riffx_pkg and the extractor RTL only.
`default_nettype none

module tb_riff_exif_chunk_extractor;
   import riffx_pkg::*;

   localparam int ITEM_TARGET = 1750;     // live bytes in the random part
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 10;

   // How a table row is checked
   typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT, CHK_TYPED} row_check_t;

   // Chunk walker modes
   typedef enum logic [2:0] {
      WALK_FILE_HDR, WALK_CHUNK_HDR, WALK_SKIP, WALK_PAD, WALK_EXIF, WALK_STOP, WALK_FOUND
   } walk_mode_t;

   typedef struct packed {
      logic [7:0]  byte_value;
      logic [31:0] total_length;
      logic        stream_start;
      row_check_t  check;
      rsp_type     typed;
   } stim_row_t;

   localparam rsp_type NO_RSP       = '0;
   localparam rsp_type EXIF_LAST_FF = '{KIND_EXIF, 8'hFF, 1'b1};
   localparam rsp_type END_MARK     = '{KIND_END, 8'h00, 1'b1};

   localparam logic [31:0] TAG_VP8  = 32'h5650_3820;
   localparam logic [31:0] TAG_VP8X = 32'h5650_3858;
   localparam logic [31:0] TAG_ICCP = 32'h4943_4350;

   localparam int N_DIRECTED = 26;
   localparam stim_row_t DIRECTED [N_DIRECTED] = '{
      // zero total length right after reset: the byte lies past the end
      '{8'hFF, 32'd0,  1'b1, CHK_SILENT, NO_RSP},
      // smallest file with an EXIF chunk: RIFF, size, WEBP, EXIF, length 1, payload
      '{8'h52, 32'd21, 1'b1, CHK_MODEL, NO_RSP},
      '{8'h49, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'h46, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'h46, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'h0D, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'h00, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'h00, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'h00, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'h57, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'h45, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'h42, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'h50, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'h45, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'h58, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'h49, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'h46, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'h01, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'h00, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'h00, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'h00, 32'd21, 1'b0, CHK_MODEL, NO_RSP},
      '{8'hFF, 32'd21, 1'b0, CHK_TYPED, EXIF_LAST_FF},
      // bad RIFF tag: the walk stops, the end marker still comes on the last byte
      '{8'h52, 32'd4,  1'b1, CHK_MODEL, NO_RSP},
      '{8'h49, 32'd4,  1'b0, CHK_MODEL, NO_RSP},
      '{8'h46, 32'd4,  1'b0, CHK_MODEL, NO_RSP},
      '{8'h58, 32'd4,  1'b0, CHK_TYPED, END_MARK}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_byte_value;
   logic [31:0] req_total_length;
   logic        req_stream_start;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_result_kind;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_payload_last;

   riff_exif_chunk_extractor dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_value   (req_byte_value),
      .req_total_length (req_total_length),
      .req_stream_start (req_stream_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_last (rsp_payload_last)
   );

   // Results still owed by the block, oldest first
   rsp_type     awaited_results[$];
   rsp_type     oldest;
   int          fail_count = 0;
   int          live_items = 0;
   int          cycle_count = 0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;

   // Bytes of the file being sent
   logic [7:0]  file_bytes[$];

   // Chunk walker state, kept in step with the block
   logic [31:0] walk_pos;
   walk_mode_t  walk_mode;
   logic [31:0] tag_acc;
   logic [31:0] len_acc;
   logic [32:0] chunk_left;
   logic        pad_owed;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Free-running cycle count; abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Receiver back-pressure: stall at the rate of the current phase
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Compare every accepted result with the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $error("unexpected result: kind %0d byte %h last %0d",
                   rsp_result_kind, rsp_payload_byte, rsp_payload_last);
            fail_count++;
         end else begin
            oldest = awaited_results.pop_front();
            if (rsp_result_kind !== oldest.result_kind) begin
               $error("result_kind: expected %0d, got %0d", oldest.result_kind, rsp_result_kind);
               fail_count++;
            end
            if (rsp_payload_byte !== oldest.payload_byte) begin
               $error("payload_byte: expected %h, got %h", oldest.payload_byte, rsp_payload_byte);
               fail_count++;
            end
            if (rsp_payload_last !== oldest.payload_last) begin
               $error("payload_last: expected %0d, got %0d", oldest.payload_last, rsp_payload_last);
               fail_count++;
            end
         end
      end
   end

   function automatic void restart_walk();
      walk_pos   = '0;
      walk_mode  = WALK_FILE_HDR;
      tag_acc    = '0;
      len_acc    = '0;
      chunk_left = '0;
      pad_owed   = 1'b0;
   endfunction

   function automatic void enter_chunk_header();
      walk_mode  = WALK_CHUNK_HDR;
      chunk_left = '0;
      pad_owed   = 1'b0;
   endfunction

   // Advance the chunk walker by one byte. live: the byte lay inside the file;
   // hit: the byte owes a result, given in res.
   function automatic void walk_byte(input logic [7:0] b, input logic [31:0] total,
                                     input logic start, output logic live,
                                     output logic hit, output rsp_type res);
      logic [31:0] pos;
      live = 1'b0;
      hit  = 1'b0;
      res  = NO_RSP;
      if (start)
         restart_walk();
      pos = walk_pos;
      // bytes at or past the total length are absorbed untouched
      if (pos >= total)
         return;
      live = 1'b1;
      case (walk_mode)
         WALK_FILE_HDR: begin
            tag_acc = {tag_acc[23:0], b};
            if (pos == TAG_BYTES - 1 && tag_acc != TAG_RIFF) begin
               walk_mode = WALK_STOP;
            end else if (pos == WALK_START - 1) begin
               if (tag_acc != TAG_WEBP)
                  walk_mode = WALK_STOP;
               else
                  enter_chunk_header();
            end
         end
         WALK_CHUNK_HDR: begin
            // tag bytes big-end first, then length little-endian
            if (chunk_left < TAG_BYTES)
               tag_acc = {tag_acc[23:0], b};
            else
               len_acc = {b, len_acc[31:8]};
            chunk_left = chunk_left + 33'd1;
            if (chunk_left >= CHUNK_HDR_BYTES) begin
               if ({2'b00, pos} + 34'd1 + {2'b00, len_acc} > {2'b00, total}) begin
                  walk_mode = WALK_STOP;
               end else if (len_acc == '0) begin
                  enter_chunk_header();
               end else if (tag_acc == TAG_EXIF) begin
                  walk_mode  = WALK_EXIF;
                  chunk_left = {1'b0, len_acc};
               end else begin
                  walk_mode  = WALK_SKIP;
                  chunk_left = {1'b0, len_acc};
                  pad_owed   = len_acc[0];
               end
            end
         end
         WALK_SKIP: begin
            if (chunk_left != '0)
               chunk_left = chunk_left - 33'd1;
            if (chunk_left == '0) begin
               if (pad_owed)
                  walk_mode = WALK_PAD;
               else
                  enter_chunk_header();
            end
         end
         WALK_PAD: enter_chunk_header();
         WALK_EXIF: begin
            hit = 1'b1;
            res.result_kind  = KIND_EXIF;
            res.payload_byte = b;
            if (chunk_left != '0)
               chunk_left = chunk_left - 33'd1;
            if (chunk_left == '0) begin
               res.payload_last = 1'b1;
               walk_mode = WALK_FOUND;
            end
         end
         default: ;
      endcase
      // position saturates at the top of the counter
      if (pos != '1)
         walk_pos = pos + 32'd1;
      // an EXIF byte wins over the end marker
      if (!hit && walk_mode != WALK_FOUND && {1'b0, pos} + 33'd1 == {1'b0, total}) begin
         hit = 1'b1;
         res = END_MARK;
      end
   endfunction

   // Offer one byte, hold it until accepted, then record what it owes
   task automatic send_byte(input logic [7:0] b, input logic [31:0] total,
                            input logic start, input row_check_t check,
                            input rsp_type typed);
      logic    live;
      logic    hit;
      rsp_type res;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_byte_value   <= b;
      req_total_length <= total;
      req_stream_start <= start;
      do
         @(posedge clock);
      while (req_stall);
      walk_byte(b, total, start, live, hit, res);
      if (live)
         live_items++;
      case (check)
         CHK_MODEL: if (hit) awaited_results.push_back(res);
         CHK_TYPED: awaited_results.push_back(typed);
         default: ;
      endcase
   endtask

   task automatic put_word_be(input logic [31:0] w);
      for (int i = 0; i < 4; i++)
         file_bytes.push_back(w[31 - 8*i -: 8]);
   endtask

   task automatic put_word_le(input logic [31:0] w);
      for (int i = 0; i < 4; i++)
         file_bytes.push_back(w[8*i +: 8]);
   endtask

   // Build the next file: mostly well-formed chunk walks with random content,
   // some with a flipped bit, some plain noise.
   task automatic compose_file(output logic noise);
      int          n_chunks;
      int          idx;
      logic [31:0] tag;
      logic [31:0] len;
      file_bytes.delete();
      noise = ($urandom_range(9) == 0);
      if (noise) begin
         repeat ($urandom_range(1, 20))
            file_bytes.push_back(8'($urandom));
         return;
      end
      put_word_be(TAG_RIFF);
      put_word_le($urandom);
      put_word_be(TAG_WEBP);
      n_chunks = $urandom_range(0, 4);
      for (int c = 0; c < n_chunks; c++) begin
         case ($urandom_range(9))
            0, 1, 2: tag = TAG_EXIF;
            3:       tag = TAG_VP8;
            4:       tag = TAG_VP8X;
            5:       tag = TAG_ICCP;
            6:       tag = $urandom;
            default: tag = (c == 0) ? TAG_EXIF : TAG_VP8;
         endcase
         case ($urandom_range(15))
            0:       len = $urandom;            // likely overruns the file
            1, 2:    len = '0;                  // empty chunk, EXIF or not
            default: len = $urandom_range(1, 9);
         endcase
         put_word_be(tag);
         put_word_le(len);
         // stop after a header whose payload will not be sent
         if (len > 32'd40)
            break;
         repeat (len)
            file_bytes.push_back(8'($urandom));
         // drop the pad byte now and then to break the walk
         if (len[0] && $urandom_range(7) != 0)
            file_bytes.push_back(8'($urandom));
      end
      if ($urandom_range(7) == 0) begin
         idx = $urandom_range(file_bytes.size() - 1);
         file_bytes[idx] = file_bytes[idx] ^ (8'h01 << $urandom_range(7));
      end
   endtask

   initial begin
      logic [31:0] total;
      logic        drift;
      logic        noise;
      int          size;
      int          target;
      int          phase;
      int          wobble;

      restart_walk();
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_byte_value   <= '0;
      req_total_length <= '0;
      req_stream_start <= 1'b0;
      rsp_stall        <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table without idling
      for (int r = 0; r < N_DIRECTED; r++)
         send_byte(DIRECTED[r].byte_value, DIRECTED[r].total_length,
                   DIRECTED[r].stream_start, DIRECTED[r].check, DIRECTED[r].typed);

      // Random files; step through the idling phases as bytes go by
      target = live_items + ITEM_TARGET;
      while (live_items < target) begin
         phase = (ITEM_TARGET - (target - live_items)) * 4 / ITEM_TARGET;
         case (phase)
            0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1:       begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
            default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
         endcase
         compose_file(noise);
         size  = file_bytes.size();
         drift = 1'b0;
         case ($urandom_range(19))
            13, 14:  total = 32'($urandom_range(size));         // cut short
            15, 16:  total = 32'(size + $urandom_range(1, 8));  // never reaches the end
            17:      total = 32'hFFFF_FFFF;
            18:      total = $urandom;
            19:      drift = 1'b1;                              // length moves per byte
            default: total = 32'(size);
         endcase
         for (int i = 0; i < size; i++) begin
            if (drift) begin
               wobble = size + $urandom_range(4) - 2;
               total  = (wobble < 0) ? 32'd0 : 32'(wobble);
            end
            send_byte(file_bytes[i], total,
                      noise ? ($urandom_range(3) == 0) : (i == 0), CHK_MODEL, NO_RSP);
         end
      end

      // Drop valid, release the receiver and drain what is still owed
      req_valid          <= 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/riffx_pkg.sv
rtl/riffx_in_stage.sv
rtl/riffx_parser.sv
rtl/riffx_out_stage.sv
rtl/riff_exif_chunk_extractor.sv
sim/tb_riff_exif_chunk_extractor.sv
